FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the tiled pixel walk RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TPW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/tpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled pixel walk package
// Shared types, register indexes and constants of the tiled pixel walk.
// ----------------------------------------------------------------------------
package tpw_pkg;

    localparam int REG_WIDTH          = 16;
    localparam int PIX_WIDTH          = 16;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int COORD_BITS_DEFAULT = 16;

    localparam logic [REG_WIDTH-1:0] CFG_RESET_VALUE = REG_WIDTH'(1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_COLUMNS = 2'd0,
        REG_IMAGE_ROWS    = 2'd1,
        REG_TILE_SIZE     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [REG_WIDTH-1:0] image_columns;
        logic [REG_WIDTH-1:0] image_rows;
        logic [REG_WIDTH-1:0] tile_size;
    } cfg_t;

    typedef struct packed {
        logic [PIX_WIDTH-1:0] pixel_row;
        logic [PIX_WIDTH-1:0] pixel_col;
        logic                 wrapped;
    } result_t;

endpackage

FILE: sv/tpw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled pixel walk configuration registers
// Decodes register writes; a defined-register write requests a walk return to origin.
// ----------------------------------------------------------------------------
module tpw_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tpw_pkg::REG_WIDTH-1:0]        cfg_data,
    output tpw_pkg::cfg_t                        cfg,
    output logic                                 restart
);

    tpw_pkg::cfg_t cfg_reg;
    tpw_pkg::cfg_t cfg_next;
    logic          hit;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_valid) begin
            unique case (tpw_pkg::cfg_index_t'(cfg_index))
                tpw_pkg::REG_IMAGE_COLUMNS: begin
                    cfg_next.image_columns = cfg_data;
                    hit = 1'b1;
                end
                tpw_pkg::REG_IMAGE_ROWS: begin
                    cfg_next.image_rows = cfg_data;
                    hit = 1'b1;
                end
                tpw_pkg::REG_TILE_SIZE: begin
                    cfg_next.tile_size = cfg_data;
                    hit = 1'b1;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // Any write to a defined register sends the walk back to the origin.
    assign restart = hit;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_columns <= tpw_pkg::CFG_RESET_VALUE;
            cfg_reg.image_rows    <= tpw_pkg::CFG_RESET_VALUE;
            cfg_reg.tile_size     <= tpw_pkg::CFG_RESET_VALUE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/tpw_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled pixel walk state
// Holds tile origins and in-tile offsets and steps them one pixel at a time.
// ----------------------------------------------------------------------------
module tpw_walk #(
    parameter int COORD_BITS = tpw_pkg::COORD_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tpw_pkg::cfg_t                    cfg,
    input  logic                             restart,
    input  logic                             step,
    output logic [tpw_pkg::PIX_WIDTH-1:0]    cur_row,
    output logic [tpw_pkg::PIX_WIDTH-1:0]    cur_col,
    output logic                             wrap_now
);

    localparam int W  = COORD_BITS;
    localparam int OW = COORD_BITS + 1;
    localparam int SW = COORD_BITS + 2;

    logic [OW-1:0] tile_row_origin_reg, tile_row_origin_next;
    logic [W-1:0]  offset_in_tile_row_reg, offset_in_tile_row_next;
    logic [OW-1:0] tile_col_origin_reg, tile_col_origin_next;
    logic [W-1:0]  offset_in_tile_col_reg, offset_in_tile_col_next;

    logic [W-1:0]  ts;
    logic [W-1:0]  rows;
    logic [W-1:0]  cols;
    logic [W-1:0]  off_row_inc;
    logic [W-1:0]  off_col_inc;
    logic [SW-1:0] row_sum;
    logic [SW-1:0] col_sum;
    logic [OW-1:0] org_row_inc;
    logic [OW-1:0] org_col_inc;
    logic          row_stays;
    logic          col_stays;
    logic          org_row_ok;
    logic          org_col_ok;

    always_comb begin
        ts   = W'(cfg.tile_size);
        if (ts == '0) begin
            ts = W'(1);
        end
        rows = W'(cfg.image_rows);
        cols = W'(cfg.image_columns);

        off_row_inc = offset_in_tile_row_reg + W'(1);
        off_col_inc = offset_in_tile_col_reg + W'(1);
        row_sum     = SW'(tile_row_origin_reg) + SW'(off_row_inc);
        col_sum     = SW'(tile_col_origin_reg) + SW'(off_col_inc);
        org_row_inc = tile_row_origin_reg + OW'(ts);
        org_col_inc = tile_col_origin_reg + OW'(ts);

        row_stays  = (off_row_inc < ts) && (row_sum < SW'(rows));
        col_stays  = (off_col_inc < ts) && (col_sum < SW'(cols));
        org_row_ok = org_row_inc < OW'(rows);
        org_col_ok = org_col_inc < OW'(cols);

        wrap_now = !row_stays && !col_stays && !org_row_ok && !org_col_ok;

        tile_row_origin_next    = tile_row_origin_reg;
        offset_in_tile_row_next = offset_in_tile_row_reg;
        tile_col_origin_next    = tile_col_origin_reg;
        offset_in_tile_col_next = offset_in_tile_col_reg;

        if (restart) begin
            tile_row_origin_next    = '0;
            offset_in_tile_row_next = '0;
            tile_col_origin_next    = '0;
            offset_in_tile_col_next = '0;
        end else if (step) begin
            // Carry ripples from the row offset up to the tile column origin.
            if (row_stays) begin
                offset_in_tile_row_next = off_row_inc;
            end else if (col_stays) begin
                offset_in_tile_row_next = '0;
                offset_in_tile_col_next = off_col_inc;
            end else if (org_row_ok) begin
                offset_in_tile_row_next = '0;
                offset_in_tile_col_next = '0;
                tile_row_origin_next    = org_row_inc;
            end else if (org_col_ok) begin
                offset_in_tile_row_next = '0;
                offset_in_tile_col_next = '0;
                tile_row_origin_next    = '0;
                tile_col_origin_next    = org_col_inc;
            end else begin
                offset_in_tile_row_next = '0;
                offset_in_tile_col_next = '0;
                tile_row_origin_next    = '0;
                tile_col_origin_next    = '0;
            end
        end
    end

    assign cur_row = tpw_pkg::PIX_WIDTH'(W'(tile_row_origin_reg + OW'(offset_in_tile_row_reg)));
    assign cur_col = tpw_pkg::PIX_WIDTH'(W'(tile_col_origin_reg + OW'(offset_in_tile_col_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_row_origin_reg    <= '0;
            offset_in_tile_row_reg <= '0;
            tile_col_origin_reg    <= '0;
            offset_in_tile_col_reg <= '0;
        end else begin
            tile_row_origin_reg    <= tile_row_origin_next;
            offset_in_tile_row_reg <= offset_in_tile_row_next;
            tile_col_origin_reg    <= tile_col_origin_next;
            offset_in_tile_col_reg <= offset_in_tile_col_next;
        end
    end

endmodule

FILE: sv/tpw_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled pixel walk result register
// Output register that accepts a new result while empty or whenever the current one leaves.
// ----------------------------------------------------------------------------
module tpw_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpw_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tpw_pkg::result_t  out_data
);

    logic             valid_reg;
    tpw_pkg::result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: sv/tiled_pixel_walk_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled pixel walk unit
// Generates pixel coordinates that visit an image tile by tile.
// ----------------------------------------------------------------------------
// Each input transaction reports the current pixel (row, column) and, when
// s_advance is set, steps the walk one pixel: down a column inside a tile,
// then across the tile's columns, then down the tile column, then across
// tiles, wrapping to the origin after the last pixel with m_wrapped set.
// Tiles are clipped at the image edges. The unit takes one transaction per
// clock; the walk state is updated in the accepting cycle by one increment and
// compare stage, and the result appears in the next cycle from the output
// register, which keeps accepting as long as its result is taken. Any write
// to a defined configuration register returns the walk to the origin; write
// configuration only while no result is outstanding.
module tiled_pixel_walk_unit #(
    parameter int COORD_BITS = tpw_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tpw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tpw_pkg::REG_WIDTH-1:0]        cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_advance,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tpw_pkg::PIX_WIDTH-1:0]        m_pixel_row,
    output logic [tpw_pkg::PIX_WIDTH-1:0]        m_pixel_col,
    output logic                                 m_wrapped
);

`include "assert_macros.svh"

    tpw_pkg::cfg_t                  cfg;
    tpw_pkg::result_t               res_in;
    tpw_pkg::result_t               res_out;
    logic                           restart;
    logic                           step;
    logic                           wrap_now;
    logic [tpw_pkg::PIX_WIDTH-1:0]  cur_row;
    logic [tpw_pkg::PIX_WIDTH-1:0]  cur_col;

    tpw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    assign step = s_valid && s_ready && s_advance;

    tpw_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .restart  (restart),
        .step     (step),
        .cur_row  (cur_row),
        .cur_col  (cur_col),
        .wrap_now (wrap_now)
    );

    always_comb begin
        res_in.pixel_row = cur_row;
        res_in.pixel_col = cur_col;
        res_in.wrapped   = s_advance && wrap_now;
    end

    tpw_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_pixel_row = res_out.pixel_row;
    assign m_pixel_col = res_out.pixel_col;
    assign m_wrapped   = res_out.wrapped;

    // A configuration write leaves the walk at the origin.
    `TPW_ASSERT_NEXT(a_restart_origin, aclk, aresetn, restart, (cur_row == '0) && (cur_col == '0), "walk not at origin after configuration write")

    // A wrapping step lands on the origin.
    `TPW_ASSERT_NEXT(a_wrap_origin, aclk, aresetn, step && wrap_now && !restart, (cur_row == '0) && (cur_col == '0), "walk not at origin after wrap")

    // A report-only transaction leaves the position untouched.
    `TPW_ASSERT_NEXT(a_hold_position, aclk, aresetn, s_valid && s_ready && !s_advance && !restart, $stable(cur_row) && $stable(cur_col), "position moved without advance")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled pixel walk unit testbench
// Drives advance/report transactions and register writes into the walk unit.
// A local copy of the walk predicts every result, and the monitor compares
// each returned pixel field by field. Image and tile settings change between
// phases, while both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [tpw_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1050;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [tpw_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [tpw_pkg::REG_WIDTH-1:0]      cfg_data = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_advance = 1'b0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [tpw_pkg::PIX_WIDTH-1:0]      m_pixel_row;
    logic [tpw_pkg::PIX_WIDTH-1:0]      m_pixel_col;
    logic                               m_wrapped;

    // Walk state and image settings as the unit should hold them.
    logic [tpw_pkg::REG_WIDTH-1:0] img_cols;
    logic [tpw_pkg::REG_WIDTH-1:0] img_rows;
    logic [tpw_pkg::REG_WIDTH-1:0] img_tile;
    logic [16:0]                   row_base;
    logic [15:0]                   row_off;
    logic [16:0]                   col_base;
    logic [15:0]                   col_off;

    logic             pending_advances[$];
    tpw_pkg::result_t expected_pixels[$];

    int unsigned src_idle_max = 0;
    int unsigned sink_idle_max = 0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    int unsigned fail_count = 0;
    int unsigned results_checked = 0;
    int unsigned wraps_seen = 0;
    int unsigned settings_used = 0;
    int unsigned items_queued = 0;

    tiled_pixel_walk_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_advance   (s_advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_row (m_pixel_row),
        .m_pixel_col (m_pixel_col),
        .m_wrapped   (m_wrapped)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void walk_to_origin();
        row_base = '0;
        row_off  = '0;
        col_base = '0;
        col_off  = '0;
    endfunction

    // Steps one pixel through the tile order; returns 1 when the walk wraps.
    function automatic logic walk_advance();
        logic [15:0] side;
        side = (img_tile == '0) ? 16'd1 : img_tile;
        row_off = row_off + 16'd1;
        if (row_off < side && 18'(row_base) + 18'(row_off) < 18'(img_rows))
            return 1'b0;
        row_off = '0;
        col_off = col_off + 16'd1;
        if (col_off < side && 18'(col_base) + 18'(col_off) < 18'(img_cols))
            return 1'b0;
        col_off = '0;
        row_base = row_base + 17'(side);
        if (row_base < 17'(img_rows))
            return 1'b0;
        row_base = '0;
        col_base = col_base + 17'(side);
        if (col_base < 17'(img_cols))
            return 1'b0;
        col_base = '0;
        return 1'b1;
    endfunction

    // The pixel is reported as it stands before the optional advance.
    function automatic tpw_pkg::result_t walk_report(input logic adv);
        tpw_pkg::result_t r;
        r.pixel_row = row_base[15:0] + row_off;
        r.pixel_col = col_base[15:0] + col_off;
        r.wrapped   = 1'b0;
        if (adv)
            r.wrapped = walk_advance();
        return r;
    endfunction

    always @(posedge aclk) begin : advance_driver
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_advance <= 1'b0;
            src_wait  <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(walk_report(s_advance));
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait <= src_wait - 1;
                    s_valid  <= 1'b0;
                end else if (pending_advances.size() > 0) begin
                    s_advance <= pending_advances.pop_front();
                    s_valid   <= 1'b1;
                    src_wait  <= $urandom_range(0, src_idle_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : pixel_monitor
        tpw_pkg::result_t want;
        int unsigned      stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result transaction: row %0d col %0d wrapped %0b",
                           m_pixel_row, m_pixel_col, m_wrapped);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    results_checked++;
                    if (m_pixel_row !== want.pixel_row) begin
                        $error("pixel_row: expected %0d, got %0d", want.pixel_row, m_pixel_row);
                        fail_count++;
                    end
                    if (m_pixel_col !== want.pixel_col) begin
                        $error("pixel_col: expected %0d, got %0d", want.pixel_col, m_pixel_col);
                        fail_count++;
                    end
                    if (m_wrapped !== want.wrapped) begin
                        $error("wrapped: expected %0b, got %0b", want.wrapped, m_wrapped);
                        fail_count++;
                    end
                    if (want.wrapped)
                        wraps_seen++;
                end
                stall = $urandom_range(0, sink_idle_max);
                sink_wait <= stall;
                m_ready   <= (stall == 0);
            end else if (sink_wait > 0) begin
                sink_wait <= sink_wait - 1;
                m_ready   <= (sink_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Returns once every queued transaction has been accepted and answered.
    task automatic wait_idle();
        @(posedge aclk);
        while (pending_advances.size() > 0 || s_valid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tpw_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [tpw_pkg::REG_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            tpw_pkg::REG_IMAGE_COLUMNS: begin
                img_cols = data;
                walk_to_origin();
            end
            tpw_pkg::REG_IMAGE_ROWS: begin
                img_rows = data;
                walk_to_origin();
            end
            tpw_pkg::REG_TILE_SIZE: begin
                img_tile = data;
                walk_to_origin();
            end
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_image(input logic [tpw_pkg::REG_WIDTH-1:0] cols,
                             input logic [tpw_pkg::REG_WIDTH-1:0] rows,
                             input logic [tpw_pkg::REG_WIDTH-1:0] side);
        write_reg(tpw_pkg::REG_IMAGE_COLUMNS, cols);
        write_reg(tpw_pkg::REG_IMAGE_ROWS, rows);
        write_reg(tpw_pkg::REG_TILE_SIZE, side);
        settings_used++;
    endtask

    task automatic queue_advances(input int unsigned count, input int unsigned adv_pct);
        for (int unsigned i = 0; i < count; i++)
            pending_advances.push_back($urandom_range(0, 99) < adv_pct);
        items_queued += count;
    endtask

    task automatic queue_pattern(input logic pattern[$]);
        foreach (pattern[i])
            pending_advances.push_back(pattern[i]);
        items_queued += pattern.size();
    endtask

    // Mostly small extents so walks wrap often, with zero and full-scale values mixed in.
    function automatic logic [tpw_pkg::REG_WIDTH-1:0] pick_extent(input int unsigned small_hi);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        else if (roll < 14)
            return 16'hFFFF;
        else if (roll < 24)
            return tpw_pkg::REG_WIDTH'($urandom());
        else
            return tpw_pkg::REG_WIDTH'($urandom_range(1, small_hi));
    endfunction

    function automatic int unsigned pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            default: return 18;
        endcase
    endfunction

    initial begin : stimulus
        logic [tpw_pkg::REG_WIDTH-1:0] cols;
        logic [tpw_pkg::REG_WIDTH-1:0] rows;
        logic [tpw_pkg::REG_WIDTH-1:0] side;
        bit                            big;
        img_cols = tpw_pkg::CFG_RESET_VALUE;
        img_rows = tpw_pkg::CFG_RESET_VALUE;
        img_tile = tpw_pkg::CFG_RESET_VALUE;
        walk_to_origin();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a 1x1 image wraps on every advance.
        src_idle_max  = 3;
        sink_idle_max = 3;
        queue_pattern('{1'b0, 1'b1, 1'b1});
        wait_idle();

        // Clipped tiles, then a write to the unused index that must not disturb the walk.
        set_image(16'd3, 16'd2, 16'd2);
        queue_pattern('{1'b1, 1'b1, 1'b1});
        wait_idle();
        write_reg(REG_SPARE, 16'hFFFF);
        queue_pattern('{1'b1, 1'b1, 1'b0, 1'b1, 1'b1});
        wait_idle();

        // A tile size of zero walks like a tile size of one.
        set_image(16'd2, 16'd2, 16'd0);
        queue_advances(5, 100);
        wait_idle();

        // Zero rows, then zero columns.
        set_image(16'd3, 16'd0, 16'd1);
        queue_advances(4, 100);
        wait_idle();
        set_image(16'd0, 16'd2, 16'd1);
        queue_advances(3, 100);
        wait_idle();

        // Full-scale image and tile.
        set_image(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_advances(3, 100);
        wait_idle();

        while (items_queued < RANDOM_ITEMS + 25) begin
            src_idle_max  = pick_idle();
            sink_idle_max = pick_idle();
            cols = pick_extent(12);
            rows = pick_extent(12);
            side = pick_extent(6);
            big  = (cols > 16'd64) || (rows > 16'd64);
            set_image(cols, rows, side);
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_SPARE, tpw_pkg::REG_WIDTH'($urandom()));
            if (big)
                queue_advances($urandom_range(5, 15), 90);
            else
                queue_advances($urandom_range(20, 60), 85);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        $display("Compared %0d pixel results over %0d image/tile settings; %0d walk wraps seen.",
                 results_checked, settings_used, wraps_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $error("timeout: the run did not finish");
        $display("== FAIL ==");
        $finish;
    end

endmodule
